[sv/decs_pkg.sv]
// Shared types and constants of the dual echo coincidence sweep block.
package decs_pkg;

    localparam int ECHO_FIELDS  = 3;
    localparam int ECHO_W       = 15;
    localparam int DIST_W       = 13;
    localparam int RAW_DIST_W   = 14;
    localparam int SUM_W        = 15;
    localparam int CNT_W        = 2;
    localparam int SAMPLE_IDX_W = 2;
    localparam int TIME_W       = 32;
    localparam int MS_W         = 16;
    localparam int ANGLE_W      = 8;

    // distance = floor(d * 34 / 125) = (d * DIST_MULT) >> DIST_SHIFT, exact for 15-bit d
    localparam int               DIST_MULT_W = 27;
    localparam int               DIST_SHIFT  = 28;
    localparam int               DIST_PROD_W = ECHO_W + DIST_MULT_W;
    localparam logic [DIST_MULT_W-1:0] DIST_MULT = 27'd73014456;

    // floor(x / 3) = (x * DIV3_MULT) >> DIV3_SHIFT, exact for 15-bit x
    localparam int              DIV3_MULT_W = 16;
    localparam int              DIV3_SHIFT  = 17;
    localparam int              DIV3_PROD_W = SUM_W + DIV3_MULT_W;
    localparam logic [DIV3_MULT_W-1:0] DIV3_MULT = 16'd43691;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MIN_DISTANCE   = 3'd0,
        REG_MAX_DISTANCE   = 3'd1,
        REG_NEAR_THRESHOLD = 3'd2,
        REG_SYNC_WINDOW    = 3'd3,
        REG_STEP_PERIOD_MS = 3'd4,
        REG_ANGLE_STEP     = 3'd5,
        REG_ANGLE_MAX      = 3'd6
    } reg_idx_t;

    localparam logic [DIST_W-1:0]  MIN_DISTANCE_RST   = 13'd32;
    localparam logic [DIST_W-1:0]  MAX_DISTANCE_RST   = 13'd6400;
    localparam logic [DIST_W-1:0]  NEAR_THRESHOLD_RST = 13'd400;
    localparam logic [MS_W-1:0]    SYNC_WINDOW_RST    = 16'd100;
    localparam logic [MS_W-1:0]    STEP_PERIOD_RST    = 16'd20;
    localparam logic [ANGLE_W-1:0] ANGLE_STEP_RST     = 8'd10;
    localparam logic [ANGLE_W-1:0] ANGLE_MAX_RST      = 8'd180;

    typedef struct packed {
        logic [DIST_W-1:0]  min_distance;
        logic [DIST_W-1:0]  max_distance;
        logic [DIST_W-1:0]  near_threshold;
        logic [MS_W-1:0]    sync_window;
        logic [MS_W-1:0]    step_period_ms;
        logic [ANGLE_W-1:0] angle_step;
        logic [ANGLE_W-1:0] angle_max;
    } cfg_t;

    typedef struct packed {
        logic                    load;
        logic                    conv;
        logic [SAMPLE_IDX_W-1:0] idx;
        logic                    div;
        logic                    upd;
    } cmd_t;

endpackage

[sv/decs_regs.sv]
// Configuration register file of the dual echo coincidence sweep block.
module decs_regs (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wen,
    input  logic [decs_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [decs_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output decs_pkg::cfg_t                     cfg
);
    import decs_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wen) begin
            case (cfg_index)
                REG_MIN_DISTANCE:   cfg_next.min_distance   = cfg_wdata[DIST_W-1:0];
                REG_MAX_DISTANCE:   cfg_next.max_distance   = cfg_wdata[DIST_W-1:0];
                REG_NEAR_THRESHOLD: cfg_next.near_threshold = cfg_wdata[DIST_W-1:0];
                REG_SYNC_WINDOW:    cfg_next.sync_window    = cfg_wdata[MS_W-1:0];
                REG_STEP_PERIOD_MS: cfg_next.step_period_ms = cfg_wdata[MS_W-1:0];
                REG_ANGLE_STEP:     cfg_next.angle_step     = cfg_wdata[ANGLE_W-1:0];
                REG_ANGLE_MAX:      cfg_next.angle_max      = cfg_wdata[ANGLE_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_distance   <= MIN_DISTANCE_RST;
            cfg_reg.max_distance   <= MAX_DISTANCE_RST;
            cfg_reg.near_threshold <= NEAR_THRESHOLD_RST;
            cfg_reg.sync_window    <= SYNC_WINDOW_RST;
            cfg_reg.step_period_ms <= STEP_PERIOD_RST;
            cfg_reg.angle_step     <= ANGLE_STEP_RST;
            cfg_reg.angle_max      <= ANGLE_MAX_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[sv/decs_ctrl.sv]
// Sequencing state machine of the dual echo coincidence sweep block.
module decs_ctrl #(
    parameter int SAMPLES_PER_READ = 3
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  logic           m_ready,
    output decs_pkg::cmd_t cmd
);
    import decs_pkg::*;

    localparam int NUM_SAMPLES = (SAMPLES_PER_READ < ECHO_FIELDS) ? SAMPLES_PER_READ
                                                                  : ECHO_FIELDS;
    localparam logic [SAMPLE_IDX_W-1:0] LAST_IDX = SAMPLE_IDX_W'(NUM_SAMPLES - 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CONV = 4'b0010,
        S_DIV  = 4'b0100,
        S_UPD  = 4'b1000
    } state_t;

    state_t                  state_reg, state_next;
    logic [SAMPLE_IDX_W-1:0] idx_reg, idx_next;
    logic                    m_valid_reg, m_valid_next;

    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        cmd.idx      = idx_reg;
        s_ready      = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    idx_next   = '0;
                    state_next = S_CONV;
                end
            end
            S_CONV: begin
                cmd.conv = 1'b1;
                if (idx_reg == LAST_IDX) begin
                    state_next = S_DIV;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_DIV: begin
                cmd.div    = 1'b1;
                state_next = S_UPD;
            end
            S_UPD: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    cmd.upd      = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

[sv/decs_datapath.sv]
// Range averaging, coincidence detection and sweep datapath.
module decs_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  decs_pkg::cmd_t                      cmd,
    input  decs_pkg::cfg_t                      cfg,
    input  logic [decs_pkg::TIME_W-1:0]         s_now_ms,
    input  logic [decs_pkg::ECHO_W-1:0]         s_echo1_first,
    input  logic [decs_pkg::ECHO_W-1:0]         s_echo1_second,
    input  logic [decs_pkg::ECHO_W-1:0]         s_echo1_third,
    input  logic [decs_pkg::ECHO_W-1:0]         s_echo2_first,
    input  logic [decs_pkg::ECHO_W-1:0]         s_echo2_second,
    input  logic [decs_pkg::ECHO_W-1:0]         s_echo2_third,
    output logic [decs_pkg::DIST_W-1:0]         m_range1,
    output logic                                m_range1_ok,
    output logic [decs_pkg::DIST_W-1:0]         m_range2,
    output logic                                m_range2_ok,
    output logic                                m_servo_write,
    output logic [decs_pkg::ANGLE_W-1:0]        m_servo_angle,
    output logic                                m_sweeping,
    output logic                                m_sweep_started,
    output logic                                m_sweep_done
);
    import decs_pkg::*;

    function automatic logic [RAW_DIST_W-1:0] dist_of(input logic [ECHO_W-1:0] d);
        logic [DIST_PROD_W-1:0] p;
        p = DIST_PROD_W'(d) * DIST_PROD_W'(DIST_MULT);
        return p[DIST_SHIFT +: RAW_DIST_W];
    endfunction

    function automatic logic [DIST_W-1:0] avg_of(input logic [SUM_W-1:0] s,
                                                 input logic [CNT_W-1:0] c);
        logic [DIV3_PROD_W-1:0] p;
        logic [DIST_W-1:0]      a;
        p = DIV3_PROD_W'(s) * DIV3_PROD_W'(DIV3_MULT);
        case (c)
            2'd1:    a = s[DIST_W-1:0];
            2'd2:    a = s[DIST_W:1];
            2'd3:    a = p[DIV3_SHIFT +: DIST_W];
            default: a = '0;
        endcase
        return a;
    endfunction

    logic [TIME_W-1:0]  now_reg;
    logic [ECHO_W-1:0]  echo1_reg [ECHO_FIELDS];
    logic [ECHO_W-1:0]  echo2_reg [ECHO_FIELDS];
    logic [SUM_W-1:0]   sum1_reg, sum2_reg;
    logic [CNT_W-1:0]   cnt1_reg, cnt2_reg;
    logic [DIST_W-1:0]  avg1_reg, avg2_reg;
    logic               ok1_reg, ok2_reg;

    logic [TIME_W-1:0]  dt1_reg, dt1_next;
    logic [TIME_W-1:0]  dt2_reg, dt2_next;
    logic               sweep_reg, sweep_next;
    logic [ANGLE_W-1:0] angle_reg, angle_next;
    logic               up_reg, up_next;
    logic [TIME_W-1:0]  last_reg, last_next;

    logic [DIST_W-1:0]  range1_reg, range2_reg;
    logic               range1_ok_reg, range2_ok_reg;
    logic               write_reg, write_next;
    logic [ANGLE_W-1:0] wangle_reg, wangle_next;
    logic               sweeping_reg;
    logic               started_reg, started_next;
    logic               done_reg, done_next;

    logic [ECHO_W-1:0]     e1, e2;
    logic [RAW_DIST_W-1:0] d1, d2;
    logic                  v1, v2;

    always_comb begin
        case (cmd.idx)
            2'd0:    begin e1 = echo1_reg[0]; e2 = echo2_reg[0]; end
            2'd1:    begin e1 = echo1_reg[1]; e2 = echo2_reg[1]; end
            2'd2:    begin e1 = echo1_reg[2]; e2 = echo2_reg[2]; end
            default: begin e1 = '0;           e2 = '0;           end
        endcase
    end

    assign d1 = dist_of(e1);
    assign d2 = dist_of(e2);
    assign v1 = (e1 != '0) && (d1 > {1'b0, cfg.min_distance})
                && (d1 < {1'b0, cfg.max_distance});
    assign v2 = (e2 != '0) && (d2 > {1'b0, cfg.min_distance})
                && (d2 < {1'b0, cfg.max_distance});

    logic               near1, near2;
    logic [TIME_W-1:0]  dt1_hit, dt2_hit, diff;
    logic               start;
    logic               sw_base, up_base;
    logic [ANGLE_W-1:0] ang_base;
    logic [TIME_W-1:0]  last_base, elapsed;
    logic               step;
    logic [ANGLE_W:0]   up_sum;

    always_comb begin
        near1     = ok1_reg && (avg1_reg < cfg.near_threshold);
        near2     = ok2_reg && (avg2_reg < cfg.near_threshold);
        dt1_hit   = near1 ? now_reg : dt1_reg;
        dt2_hit   = near2 ? now_reg : dt2_reg;
        diff      = (dt1_hit > dt2_hit) ? (dt1_hit - dt2_hit) : (dt2_hit - dt1_hit);
        start     = !sweep_reg && near1 && near2 && (diff < {16'd0, cfg.sync_window});
        sw_base   = sweep_reg || start;
        up_base   = start ? 1'b1 : up_reg;
        ang_base  = start ? '0 : angle_reg;
        last_base = start ? '0 : last_reg;
        elapsed   = now_reg - last_base;
        step      = sw_base && (elapsed >= {16'd0, cfg.step_period_ms});
        up_sum    = {1'b0, ang_base} + {1'b0, cfg.angle_step};

        dt1_next     = dt1_hit;
        dt2_next     = dt2_hit;
        sweep_next   = sw_base;
        angle_next   = ang_base;
        up_next      = up_base;
        last_next    = last_base;
        write_next   = 1'b0;
        wangle_next  = '0;
        started_next = start;
        done_next    = 1'b0;
        if (step) begin
            last_next   = now_reg;
            write_next  = 1'b1;
            wangle_next = ang_base;
            if (up_base) begin
                if (up_sum >= {1'b0, cfg.angle_max}) begin
                    angle_next = cfg.angle_max;
                    up_next    = 1'b0;
                end else begin
                    angle_next = up_sum[ANGLE_W-1:0];
                end
            end else if (ang_base <= cfg.angle_step) begin
                angle_next = '0;
                sweep_next = 1'b0;
                dt1_next   = '0;
                dt2_next   = '0;
                done_next  = 1'b1;
            end else begin
                angle_next = ang_base - cfg.angle_step;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            now_reg      <= s_now_ms;
            echo1_reg[0] <= s_echo1_first;
            echo1_reg[1] <= s_echo1_second;
            echo1_reg[2] <= s_echo1_third;
            echo2_reg[0] <= s_echo2_first;
            echo2_reg[1] <= s_echo2_second;
            echo2_reg[2] <= s_echo2_third;
            sum1_reg     <= '0;
            sum2_reg     <= '0;
            cnt1_reg     <= '0;
            cnt2_reg     <= '0;
        end
        if (cmd.conv) begin
            if (v1) begin
                sum1_reg <= sum1_reg + SUM_W'(d1);
                cnt1_reg <= cnt1_reg + 1'b1;
            end
            if (v2) begin
                sum2_reg <= sum2_reg + SUM_W'(d2);
                cnt2_reg <= cnt2_reg + 1'b1;
            end
        end
        if (cmd.div) begin
            avg1_reg <= avg_of(sum1_reg, cnt1_reg);
            avg2_reg <= avg_of(sum2_reg, cnt2_reg);
            ok1_reg  <= (cnt1_reg != '0);
            ok2_reg  <= (cnt2_reg != '0);
        end
        if (cmd.upd) begin
            range1_reg    <= avg1_reg;
            range2_reg    <= avg2_reg;
            range1_ok_reg <= ok1_reg;
            range2_ok_reg <= ok2_reg;
            write_reg     <= write_next;
            wangle_reg    <= wangle_next;
            sweeping_reg  <= sweep_next;
            started_reg   <= started_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dt1_reg   <= '0;
            dt2_reg   <= '0;
            sweep_reg <= 1'b0;
            angle_reg <= '0;
            up_reg    <= 1'b1;
            last_reg  <= '0;
        end else if (cmd.upd) begin
            dt1_reg   <= dt1_next;
            dt2_reg   <= dt2_next;
            sweep_reg <= sweep_next;
            angle_reg <= angle_next;
            up_reg    <= up_next;
            last_reg  <= last_next;
        end
    end

    assign m_range1        = range1_reg;
    assign m_range1_ok     = range1_ok_reg;
    assign m_range2        = range2_reg;
    assign m_range2_ok     = range2_ok_reg;
    assign m_servo_write   = write_reg;
    assign m_servo_angle   = wangle_reg;
    assign m_sweeping      = sweeping_reg;
    assign m_sweep_started = started_reg;
    assign m_sweep_done    = done_reg;

endmodule

[sv/dual_echo_coincidence_sweep_top.sv]
// Top level of the dual echo coincidence sweep block.
// Flow: load the input, convert N = min(SAMPLES_PER_READ, 3) samples, divide, update.
// No new input is taken until the last result is registered and the output register is free;
// the sample loop converts one echo per sensor per cycle on one shared multiplier each.
// Reset: synchronous active-low aresetn clears sweep state and loads register defaults.
module dual_echo_coincidence_sweep_top #(
    parameter int SAMPLES_PER_READ = 3
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wen,
    input  logic [decs_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [decs_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [decs_pkg::TIME_W-1:0]         s_now_ms,
    input  logic [decs_pkg::ECHO_W-1:0]         s_echo1_first,
    input  logic [decs_pkg::ECHO_W-1:0]         s_echo1_second,
    input  logic [decs_pkg::ECHO_W-1:0]         s_echo1_third,
    input  logic [decs_pkg::ECHO_W-1:0]         s_echo2_first,
    input  logic [decs_pkg::ECHO_W-1:0]         s_echo2_second,
    input  logic [decs_pkg::ECHO_W-1:0]         s_echo2_third,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [decs_pkg::DIST_W-1:0]         m_range1,
    output logic                                m_range1_ok,
    output logic [decs_pkg::DIST_W-1:0]         m_range2,
    output logic                                m_range2_ok,
    output logic                                m_servo_write,
    output logic [decs_pkg::ANGLE_W-1:0]        m_servo_angle,
    output logic                                m_sweeping,
    output logic                                m_sweep_started,
    output logic                                m_sweep_done
);
    import decs_pkg::*;

    cfg_t cfg;
    cmd_t cmd;

    decs_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    decs_ctrl #(
        .SAMPLES_PER_READ (SAMPLES_PER_READ)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    decs_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .cfg             (cfg),
        .s_now_ms        (s_now_ms),
        .s_echo1_first   (s_echo1_first),
        .s_echo1_second  (s_echo1_second),
        .s_echo1_third   (s_echo1_third),
        .s_echo2_first   (s_echo2_first),
        .s_echo2_second  (s_echo2_second),
        .s_echo2_third   (s_echo2_third),
        .m_range1        (m_range1),
        .m_range1_ok     (m_range1_ok),
        .m_range2        (m_range2),
        .m_range2_ok     (m_range2_ok),
        .m_servo_write   (m_servo_write),
        .m_servo_angle   (m_servo_angle),
        .m_sweeping      (m_sweeping),
        .m_sweep_started (m_sweep_started),
        .m_sweep_done    (m_sweep_done)
    );

    a_done_ends_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_sweep_done |-> m_servo_write && !m_sweeping)
        else $error("sweep end without a final write or with sweep still active");

    a_start_sweeps: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_sweep_started |-> m_sweeping)
        else $error("sweep started but not active");

    a_no_write_zero_angle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_servo_write |-> m_servo_angle == '0)
        else $error("servo angle nonzero without a write");

    a_one_item_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken again while an item is in progress");

endmodule
